>>> hw/rtl/efla_pkg.sv
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and constants of the explicit free-list allocator: channel
// payloads, operation and status codes, and the controller/datapath command
// and status groups.
// ----------------------------------------------------------------------------
package efla_pkg;

	localparam int ADDR_W    = 32;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	// request opcodes
	localparam logic [1:0] OP_INIT   = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NULL   = 2'd1;
	localparam logic [1:0] ST_OOM    = 2'd2;
	localparam logic [1:0] ST_NOINIT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK      = 2'd1;

	localparam logic [CFG_W-1:0] LIMIT_RST = 17'd65536;
	localparam logic [CFG_W-1:0] CHUNK_RST = 17'd512;

	// boundary tag constants
	localparam logic [DATA_W-1:0] MIN_BLOCK    = 32'd16;
	localparam logic [DATA_W-1:0] ALLOC_BIT    = 32'd1;
	localparam logic [DATA_W-1:0] SIZE_MASK    = 32'hFFFF_FFF8;
	localparam logic [DATA_W-1:0] PROLOGUE_TAG = 32'd9;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [16:0] req_size;
		logic [15:0] block_offset;
	} in_t;

	typedef struct packed {
		logic [15:0] result_offset;
		logic [1:0]  status;
	} out_t;

	// memory address base
	typedef enum logic [3:0] {
		B_ZERO, B_BP, B_BPSZ, B_CUR, B_UX, B_LP, B_LN, B_PB, B_NB, B_HEAD, B_PTR
	} base_t;

	// memory address offset
	typedef enum logic [2:0] {
		O_0, O_P4, O_P8, O_P12, O_M4, O_M8
	} ofs_t;

	// memory write data
	typedef enum logic [2:0] {
		W_ZERO, W_PRO, W_EPI, W_TAG, W_HEAD, W_LN, W_LP, W_BP
	} wsel_t;

	// datapath register action
	typedef enum logic [4:0] {
		A_NONE, A_ACCEPT, A_INIT, A_READY, A_ALLOC_START, A_GS_ALLOC, A_GROW,
		A_PF, A_NB, A_UX_PB, A_UX_NB, A_UX_BP, A_LP, A_LN, A_HEAD_LN, A_SZ_ADD,
		A_BP_PB, A_HEAD_BP, A_CUR_NEXT, A_BP_CUR, A_CSZ, A_RES, A_SZ_CSZ,
		A_SZ_ASZ, A_SPLIT, A_FREE_LD
	} act_t;

	typedef struct packed {
		logic       mem_re;
		logic       mem_we;
		base_t      base;
		ofs_t       ofs;
		wsel_t      wsel;
		logic       tag_alloc;
		act_t       act;
		logic       out_load;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       ready;
		logic       req_zero;
		logic       ptr_zero;
		logic       lim_lt16;
		logic       grow_fail;
		logic       no_more;
		logic       fit;
		logic       rd_alloc;
		logic       lp_zero;
		logic       ln_zero;
		logic       head_zero;
		logic       split_ok;
		logic       free_bad;
		logic       can_load;
	} sts_t;

endpackage

>>> hw/rtl/explicit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// explicit_free_list_allocator
// First-fit heap allocator with boundary tags and an explicit free list,
// built as a sequencer over a single-port heap word memory.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall) carries one request: init, alloc or free.
//   out channel (out_valid/out_stall) returns one result per request.
//   cfg channel (cfg_valid/cfg_ready) sets the heap limit and chunk size;
//   write it only while no request is in flight. cfg_ready is always high.
// Flow: one request at a time; every memory access uses the single memory
//   port. alloc walks the free list first-fit, passing over entries that
//   do not fit, extends the heap when none fits, then carves the chosen
//   block with or without a split; an extension coalesces with a free
//   block below. free coalesces with none, one or two free neighbours.
// A request is taken again the cycle after its result enters the output
//   register, even while that result still waits on out_stall; a finished
//   request holds its result until the output register frees.
// Reset: heap not initialized, empty free list, break at zero, defaults
//   of 65536 bytes limit and 512 bytes chunk. Heap memory is not cleared.
module explicit_free_list_allocator #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  efla_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output efla_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [efla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [efla_pkg::CFG_W-1:0]     cfg_data
);
	import efla_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;

	assign in_stall  = !idle;
	assign cfg_ready = 1'b1;

	// sequencer
	efla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.idle     (idle),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memory and registers
	efla_dp #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> hw/rtl/efla_dp.sv
// ----------------------------------------------------------------------------
// efla_dp
// Allocator datapath: heap word memory, address and tag arithmetic, the
// working registers of the sequencer, configuration registers and the
// result register.
// ----------------------------------------------------------------------------
module efla_dp #(
	parameter int HEAP_BYTES = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  efla_pkg::in_t                      in_data,
	input  logic                               cfg_valid,
	input  logic [efla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [efla_pkg::CFG_W-1:0]         cfg_data,
	input  efla_pkg::cmd_t                     cmd,
	output efla_pkg::sts_t                     sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output efla_pkg::out_t                     out_data
);
	import efla_pkg::*;

	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int IW    = $clog2(DEPTH);
	localparam int SW    = $clog2(HEAP_BYTES / 16 + 2);
	localparam logic [SW-1:0] STEPS_INIT = SW'(HEAP_BYTES / 16 + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic              rin_q;

	logic [CFG_W-1:0]  lim_q, chunk_q;
	logic              ready_q, out_valid_q;
	logic [ADDR_W-1:0] head_q, brk_q;
	logic [ADDR_W-1:0] bp_q, sz_q, pf_q, nb_q, pb_q, ux_q, lp_q, ln_q;
	logic [ADDR_W-1:0] cur_q, asz_q, gs_q, csz_q, res_q;
	logic [SW-1:0]     steps_q;
	logic [1:0]        op_q;
	logic [16:0]       req_q;
	logic [15:0]       ptr_q;
	out_t              out_q;

	logic [DATA_W-1:0] rdata, rsize, wdata;
	logic [ADDR_W-1:0] lim_now, chunk_rnd, chunk_now, asz_c, ptr32, bpsz;
	logic [ADDR_W-1:0] base, ofs, addr;
	logic              addr_in;
	logic [IW-1:0]     addr_idx;

	// derived limits and sizes
	assign ptr32     = {16'd0, ptr_q};
	assign bpsz      = bp_q + sz_q;
	assign lim_now   = (32'(lim_q) < 32'(HEAP_BYTES)) ? 32'(lim_q) : 32'(HEAP_BYTES);
	assign chunk_rnd = (32'(chunk_q) + 32'd7) & SIZE_MASK;
	assign chunk_now = (chunk_rnd < MIN_BLOCK) ? MIN_BLOCK : chunk_rnd;
	assign asz_c     = (req_q <= 17'd8) ? MIN_BLOCK : ((32'(req_q) + 32'd15) & SIZE_MASK);

	// read data, zero beyond the memory
	assign rdata = rin_q ? rdata_q : '0;
	assign rsize = rdata & SIZE_MASK;

	// address generation
	always_comb begin
		case (cmd.base)
			B_BP:    base = bp_q;
			B_BPSZ:  base = bpsz;
			B_CUR:   base = cur_q;
			B_UX:    base = ux_q;
			B_LP:    base = lp_q;
			B_LN:    base = ln_q;
			B_PB:    base = pb_q;
			B_NB:    base = nb_q;
			B_HEAD:  base = head_q;
			B_PTR:   base = ptr32;
			default: base = '0;
		endcase
		case (cmd.ofs)
			O_P4:    ofs = 32'd4;
			O_P8:    ofs = 32'd8;
			O_P12:   ofs = 32'd12;
			O_M4:    ofs = 32'hFFFF_FFFC;
			O_M8:    ofs = 32'hFFFF_FFF8;
			default: ofs = '0;
		endcase
	end

	assign addr     = base + ofs;
	assign addr_in  = (addr[ADDR_W-1:2] < 30'(DEPTH));
	assign addr_idx = addr[IW+1:2];

	// write data
	always_comb begin
		case (cmd.wsel)
			W_PRO:   wdata = PROLOGUE_TAG;
			W_EPI:   wdata = ALLOC_BIT;
			W_TAG:   wdata = sz_q | (cmd.tag_alloc ? ALLOC_BIT : '0);
			W_HEAD:  wdata = head_q;
			W_LN:    wdata = ln_q;
			W_LP:    wdata = lp_q;
			W_BP:    wdata = bp_q;
			default: wdata = '0;
		endcase
	end

	// heap memory, one access a cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_we && addr_in) begin
			mem_q[addr_idx] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem_q[addr_idx];
			rin_q   <= addr_in;
		end
	end

	// configuration, heap state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q       <= LIMIT_RST;
			chunk_q     <= CHUNK_RST;
			ready_q     <= 1'b0;
			head_q      <= '0;
			brk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == CFG_HEAP_LIMIT) begin
				lim_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == CFG_CHUNK) begin
				chunk_q <= cfg_data;
			end
			case (cmd.act)
				A_INIT: begin
					ready_q <= 1'b0;
					head_q  <= '0;
					brk_q   <= (lim_now < MIN_BLOCK) ? '0 : MIN_BLOCK;
				end
				A_READY:   ready_q <= 1'b1;
				A_GROW:    brk_q   <= brk_q + gs_q;
				A_HEAD_LN: head_q  <= ln_q;
				A_HEAD_BP: head_q  <= bp_q;
				default: ;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.act)
			A_ACCEPT: begin
				op_q  <= in_data.opcode;
				req_q <= in_data.req_size;
				ptr_q <= in_data.block_offset;
			end
			A_READY: gs_q <= chunk_now;
			A_ALLOC_START: begin
				asz_q   <= asz_c;
				cur_q   <= head_q;
				steps_q <= STEPS_INIT;
			end
			A_GS_ALLOC: gs_q <= (asz_q > chunk_now) ? asz_q : chunk_now;
			A_GROW: begin
				bp_q <= brk_q;
				sz_q <= gs_q;
			end
			A_PF: pf_q <= rdata;
			A_NB: begin
				nb_q <= bpsz;
				pb_q <= bp_q - (pf_q & SIZE_MASK);
			end
			A_UX_PB:  ux_q <= pb_q;
			A_UX_NB:  ux_q <= nb_q;
			A_UX_BP:  ux_q <= bp_q;
			A_LP:     lp_q <= rdata;
			A_LN:     ln_q <= rdata;
			A_SZ_ADD: sz_q <= sz_q + rsize;
			A_BP_PB:  bp_q <= pb_q;
			A_CUR_NEXT: begin
				cur_q   <= rdata;
				steps_q <= steps_q - SW'(1);
			end
			A_BP_CUR: bp_q  <= cur_q;
			A_CSZ:    csz_q <= rsize;
			A_RES:    res_q <= bp_q;
			A_SZ_CSZ: sz_q  <= csz_q;
			A_SZ_ASZ: sz_q  <= asz_q;
			A_SPLIT: begin
				bp_q <= bp_q + asz_q;
				sz_q <= csz_q - asz_q;
			end
			A_FREE_LD: begin
				bp_q <= ptr32;
				sz_q <= rsize;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q.status        <= cmd.out_status;
			out_q.result_offset <= (cmd.out_status == ST_OK && op_q == OP_ALLOC) ?
				res_q[15:0] : 16'd0;
		end
	end

	// status to the controller
	always_comb begin
		sts.op        = op_q;
		sts.ready     = ready_q;
		sts.req_zero  = (req_q == '0);
		sts.ptr_zero  = (ptr_q == '0);
		sts.lim_lt16  = (lim_now < MIN_BLOCK);
		sts.grow_fail = ((brk_q + gs_q) > lim_now);
		sts.no_more   = (cur_q == '0) || (steps_q == '0);
		sts.fit       = !rdata[0] && (asz_q <= rsize);
		sts.rd_alloc  = rdata[0];
		sts.lp_zero   = (lp_q == '0);
		sts.ln_zero   = (ln_q == '0);
		sts.head_zero = (head_q == '0);
		sts.split_ok  = (csz_q >= asz_q) && ((csz_q - asz_q) >= MIN_BLOCK);
		sts.free_bad  = (ptr_q[2:0] != 3'd0) || (ptr32 < MIN_BLOCK) || (ptr32 >= brk_q) ||
			!rdata[0] || (rsize < MIN_BLOCK) || (rsize > (brk_q - (ptr32 - 32'd4)));
		sts.can_load  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/efla_ctrl.sv
// ----------------------------------------------------------------------------
// efla_ctrl
// Allocator sequencer: walks init, alloc and free through memory steps,
// with boundary-tag write, list unlink and list push as shared subroutines.
// ----------------------------------------------------------------------------
module efla_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           idle,
	input  efla_pkg::sts_t sts,
	output efla_pkg::cmd_t cmd
);
	import efla_pkg::*;

	typedef enum logic [46:0] {
		S_IDLE = 47'd1 << 0,   S_START = 47'd1 << 1,  S_I0 = 47'd1 << 2,
		S_I1 = 47'd1 << 3,     S_I2 = 47'd1 << 4,     S_I3 = 47'd1 << 5,
		S_A0 = 47'd1 << 6,     S_F0 = 47'd1 << 7,     S_F1 = 47'd1 << 8,
		S_F2 = 47'd1 << 9,     S_GNF = 47'd1 << 10,   S_G0 = 47'd1 << 11,
		S_G2 = 47'd1 << 12,    S_M0 = 47'd1 << 13,    S_M1 = 47'd1 << 14,
		S_M2 = 47'd1 << 15,    S_MUP = 47'd1 << 16,   S_MUN = 47'd1 << 17,
		S_MSP = 47'd1 << 18,   S_MSP1 = 47'd1 << 19,  S_MSN = 47'd1 << 20,
		S_MSN1 = 47'd1 << 21,  S_MST = 47'd1 << 22,   S_MPU = 47'd1 << 23,
		S_MEND = 47'd1 << 24,  S_C0 = 47'd1 << 25,    S_C1 = 47'd1 << 26,
		S_C2 = 47'd1 << 27,    S_C2S = 47'd1 << 28,   S_C2N = 47'd1 << 29,
		S_C3 = 47'd1 << 30,    S_C4 = 47'd1 << 31,    S_C4B = 47'd1 << 32,
		S_C5 = 47'd1 << 33,    S_R0 = 47'd1 << 34,    S_R1 = 47'd1 << 35,
		S_T0 = 47'd1 << 36,    S_T1 = 47'd1 << 37,    S_U0 = 47'd1 << 38,
		S_U1 = 47'd1 << 39,    S_U2 = 47'd1 << 40,    S_U3 = 47'd1 << 41,
		S_U4 = 47'd1 << 42,    S_P0 = 47'd1 << 43,    S_P1 = 47'd1 << 44,
		S_P2 = 47'd1 << 45,    S_DONE = 47'd1 << 46
	} state_t;

	state_t     state_q, state_d, ret_q, ret_d;
	logic       tag_q, tag_d, pfree_q, pfree_d, nfree_q, nfree_d;
	logic [1:0] st_q, st_d;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			tag_q   <= 1'b0;
			pfree_q <= 1'b0;
			nfree_q <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			tag_q   <= tag_d;
			pfree_q <= pfree_d;
			nfree_q <= nfree_d;
			st_q    <= st_d;
		end
	end

	assign idle = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		tag_d   = tag_q;
		pfree_d = pfree_q;
		nfree_d = nfree_q;
		st_d    = st_q;

		cmd.mem_re     = 1'b0;
		cmd.mem_we     = 1'b0;
		cmd.base       = B_ZERO;
		cmd.ofs        = O_0;
		cmd.wsel       = W_ZERO;
		cmd.tag_alloc  = tag_q;
		cmd.act        = A_NONE;
		cmd.out_load   = 1'b0;
		cmd.out_status = st_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = A_ACCEPT;
					state_d = S_START;
				end
			end
			S_START: begin
				case (sts.op)
					OP_INIT:  state_d = S_I0;
					OP_ALLOC: state_d = S_A0;
					OP_FREE:  state_d = S_R0;
					default: begin
						st_d    = ST_NULL;
						state_d = S_DONE;
					end
				endcase
			end

			// init: prologue, epilogue, first chunk
			S_I0: begin
				cmd.act = A_INIT;
				if (sts.lim_lt16) begin
					st_d    = ST_OOM;
					state_d = S_DONE;
				end else begin
					cmd.mem_we = 1'b1;
					state_d    = S_I1;
				end
			end
			S_I1: begin
				cmd.mem_we = 1'b1;
				cmd.ofs    = O_P4;
				cmd.wsel   = W_PRO;
				state_d    = S_I2;
			end
			S_I2: begin
				cmd.mem_we = 1'b1;
				cmd.ofs    = O_P8;
				cmd.wsel   = W_PRO;
				state_d    = S_I3;
			end
			S_I3: begin
				cmd.mem_we = 1'b1;
				cmd.ofs    = O_P12;
				cmd.wsel   = W_EPI;
				cmd.act    = A_READY;
				state_d    = S_G0;
			end

			// alloc: first-fit walk
			S_A0: begin
				if (!sts.ready) begin
					st_d    = ST_NOINIT;
					state_d = S_DONE;
				end else if (sts.req_zero) begin
					st_d    = ST_NULL;
					state_d = S_DONE;
				end else begin
					cmd.act = A_ALLOC_START;
					state_d = S_F0;
				end
			end
			S_F0: begin
				if (sts.no_more) begin
					state_d = S_GNF;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.base   = B_CUR;
					cmd.ofs    = O_M4;
					state_d    = S_F1;
				end
			end
			S_F1: begin
				if (sts.fit) begin
					cmd.act = A_BP_CUR;
					state_d = S_C0;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.base   = B_CUR;
					cmd.ofs    = O_P4;
					state_d    = S_F2;
				end
			end
			S_F2: begin
				cmd.act = A_CUR_NEXT;
				state_d = S_F0;
			end
			S_GNF: begin
				cmd.act = A_GS_ALLOC;
				state_d = S_G0;
			end

			// heap extension
			S_G0: begin
				if (sts.grow_fail) begin
					st_d    = ST_OOM;
					state_d = S_DONE;
				end else begin
					cmd.act = A_GROW;
					tag_d   = 1'b0;
					ret_d   = S_G2;
					state_d = S_T0;
				end
			end
			S_G2: begin
				cmd.mem_we = 1'b1;
				cmd.base   = B_BPSZ;
				cmd.ofs    = O_M4;
				cmd.wsel   = W_EPI;
				state_d    = S_M0;
			end

			// coalesce with neighbours
			S_M0: begin
				cmd.mem_re = 1'b1;
				cmd.base   = B_BP;
				cmd.ofs    = O_M8;
				state_d    = S_M1;
			end
			S_M1: begin
				cmd.act    = A_PF;
				pfree_d    = !sts.rd_alloc;
				cmd.mem_re = 1'b1;
				cmd.base   = B_BPSZ;
				cmd.ofs    = O_M4;
				state_d    = S_M2;
			end
			S_M2: begin
				cmd.act = A_NB;
				nfree_d = !sts.rd_alloc;
				state_d = S_MUP;
			end
			S_MUP: begin
				if (pfree_q) begin
					cmd.act = A_UX_PB;
					ret_d   = S_MUN;
					state_d = S_U0;
				end else begin
					state_d = S_MUN;
				end
			end
			S_MUN: begin
				if (nfree_q) begin
					cmd.act = A_UX_NB;
					ret_d   = S_MSP;
					state_d = S_U0;
				end else begin
					state_d = S_MSP;
				end
			end
			S_MSP: begin
				if (pfree_q) begin
					cmd.mem_re = 1'b1;
					cmd.base   = B_PB;
					cmd.ofs    = O_M4;
					state_d    = S_MSP1;
				end else begin
					state_d = S_MSN;
				end
			end
			S_MSP1: begin
				cmd.act = A_SZ_ADD;
				state_d = S_MSN;
			end
			S_MSN: begin
				if (nfree_q) begin
					cmd.mem_re = 1'b1;
					cmd.base   = B_NB;
					cmd.ofs    = O_M4;
					state_d    = S_MSN1;
				end else begin
					state_d = S_MST;
				end
			end
			S_MSN1: begin
				cmd.act = A_SZ_ADD;
				state_d = S_MST;
			end
			S_MST: begin
				if (!pfree_q && !nfree_q) begin
					state_d = S_MPU;
				end else begin
					if (pfree_q) begin
						cmd.act = A_BP_PB;
					end
					tag_d   = 1'b0;
					ret_d   = S_MPU;
					state_d = S_T0;
				end
			end
			S_MPU: begin
				ret_d   = S_MEND;
				state_d = S_P0;
			end
			S_MEND: begin
				if (sts.op == OP_ALLOC) begin
					state_d = S_C0;
				end else begin
					st_d    = ST_OK;
					state_d = S_DONE;
				end
			end

			// carve the chosen block
			S_C0: begin
				cmd.mem_re = 1'b1;
				cmd.base   = B_BP;
				cmd.ofs    = O_M4;
				state_d    = S_C1;
			end
			S_C1: begin
				cmd.act = A_CSZ;
				state_d = S_C2;
			end
			S_C2: begin
				cmd.act = A_RES;
				st_d    = ST_OK;
				state_d = sts.split_ok ? S_C2S : S_C2N;
			end
			S_C2S: begin
				cmd.act = A_UX_BP;
				ret_d   = S_C3;
				state_d = S_U0;
			end
			S_C3: begin
				cmd.act = A_SZ_ASZ;
				tag_d   = 1'b1;
				ret_d   = S_C4;
				state_d = S_T0;
			end
			S_C4: begin
				cmd.act = A_SPLIT;
				tag_d   = 1'b0;
				ret_d   = S_C4B;
				state_d = S_T0;
			end
			S_C4B: begin
				ret_d   = S_DONE;
				state_d = S_P0;
			end
			S_C2N: begin
				cmd.act = A_SZ_CSZ;
				tag_d   = 1'b1;
				ret_d   = S_C5;
				state_d = S_T0;
			end
			S_C5: begin
				cmd.act = A_UX_BP;
				ret_d   = S_DONE;
				state_d = S_U0;
			end

			// free: header check
			S_R0: begin
				if (!sts.ready) begin
					st_d    = ST_NOINIT;
					state_d = S_DONE;
				end else if (sts.ptr_zero) begin
					st_d    = ST_NULL;
					state_d = S_DONE;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.base   = B_PTR;
					cmd.ofs    = O_M4;
					state_d    = S_R1;
				end
			end
			S_R1: begin
				if (sts.free_bad) begin
					st_d    = ST_NULL;
					state_d = S_DONE;
				end else begin
					cmd.act = A_FREE_LD;
					tag_d   = 1'b0;
					ret_d   = S_M0;
					state_d = S_T0;
				end
			end

			// header and footer tags
			S_T0: begin
				cmd.mem_we = 1'b1;
				cmd.base   = B_BP;
				cmd.ofs    = O_M4;
				cmd.wsel   = W_TAG;
				state_d    = S_T1;
			end
			S_T1: begin
				cmd.mem_we = 1'b1;
				cmd.base   = B_BPSZ;
				cmd.ofs    = O_M8;
				cmd.wsel   = W_TAG;
				state_d    = ret_q;
			end

			// unlink block from the free list
			S_U0: begin
				cmd.mem_re = 1'b1;
				cmd.base   = B_UX;
				state_d    = S_U1;
			end
			S_U1: begin
				cmd.act    = A_LP;
				cmd.mem_re = 1'b1;
				cmd.base   = B_UX;
				cmd.ofs    = O_P4;
				state_d    = S_U2;
			end
			S_U2: begin
				cmd.act = A_LN;
				state_d = S_U3;
			end
			S_U3: begin
				if (sts.lp_zero) begin
					cmd.act = A_HEAD_LN;
				end else begin
					cmd.mem_we = 1'b1;
					cmd.base   = B_LP;
					cmd.ofs    = O_P4;
					cmd.wsel   = W_LN;
				end
				state_d = S_U4;
			end
			S_U4: begin
				if (!sts.ln_zero) begin
					cmd.mem_we = 1'b1;
					cmd.base   = B_LN;
					cmd.wsel   = W_LP;
				end
				state_d = ret_q;
			end

			// push block at the list front
			S_P0: begin
				cmd.mem_we = 1'b1;
				cmd.base   = B_BP;
				cmd.ofs    = O_P4;
				cmd.wsel   = W_HEAD;
				state_d    = S_P1;
			end
			S_P1: begin
				if (!sts.head_zero) begin
					cmd.mem_we = 1'b1;
					cmd.base   = B_HEAD;
					cmd.wsel   = W_BP;
				end
				state_d = S_P2;
			end
			S_P2: begin
				cmd.act    = A_HEAD_BP;
				cmd.mem_we = 1'b1;
				cmd.base   = B_BP;
				cmd.wsel   = W_ZERO;
				state_d    = ret_q;
			end

			// result transfer into the output register
			S_DONE: begin
				if (sts.can_load) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/efla_checker.sv
// ----------------------------------------------------------------------------
// efla_checker
// Port-level checks of the allocator: result hold under stall, offset
// cleared on failure, and busy after a request transfer.
// ----------------------------------------------------------------------------
module efla_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input efla_pkg::out_t out_data
);
	import efla_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// failed results carry no offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.result_offset == 16'd0)
		else $error("offset on failed result");

	// one request in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

endmodule

bind explicit_free_list_allocator efla_checker u_efla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
